@@ src/nsrb_pkg.sv @@
// shared types and constants for the ntp server response builder
// used by every module under src
`timescale 1ns / 1ps
`default_nettype none

package nsrb_pkg;

    localparam int REPLY_LEN   = 48;
    localparam int REPLY_W     = REPLY_LEN * 8;
    localparam int ORIGIN_AT   = 40;
    localparam int ORIGIN_LEN  = 8;
    localparam int POS_W       = $clog2(REPLY_LEN + 1);
    localparam int ORIGIN_IDX_W = $clog2(ORIGIN_LEN);
    localparam int CNT_W       = $clog2(REPLY_LEN);

    localparam int SEC_W  = 32;
    localparam int NS_W   = 30;
    localparam int FRAC_W = 32;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 8;

    // fraction = (ns * ceil(2^74 / 5^9)) >> 51, exact for any 30-bit ns
    // the 54-bit multiplier constant is split into two 27-bit halves
    localparam int                  FRAC_M_W    = 27;
    localparam logic [FRAC_M_W-1:0] FRAC_M_HI   = 27'd72057594;
    localparam logic [FRAC_M_W-1:0] FRAC_M_LO   = 27'd5090602;
    localparam int                  FRAC_PROD_W = NS_W + FRAC_M_W;
    localparam int                  FRAC_SUM_W  = FRAC_PROD_W + 1;
    localparam int                  FRAC_LSB    = 51 - FRAC_M_W;

    localparam logic [SEC_W-1:0] EPOCH_SHIFT = 32'd2208988800;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // fixed header bytes
    localparam logic [7:0] HDR_FLAGS   = 8'h1c;
    localparam logic [7:0] HDR_STRATUM = 8'h01;
    localparam logic [7:0] HDR_POLL    = 8'h04;
    localparam logic [7:0] HDR_PREC    = 8'hf7;
    localparam logic [7:0] HDR_DISP    = 8'h50;
    localparam logic [7:0] REFID_G     = 8'h47;
    localparam logic [7:0] REFID_P     = 8'h50;
    localparam logic [7:0] REFID_S     = 8'h53;

    typedef enum logic {
        ACT_REQUEST = 1'b0,
        ACT_SYNC    = 1'b1
    } action_t;

    typedef struct packed {
        logic [1:0]        pad;
        logic [NS_W-1:0]   time_nanoseconds;
        logic [SEC_W-1:0]  time_seconds;
        logic [7:0]        data_byte;
    } in_data_t;

    typedef logic [0:ORIGIN_LEN-1][7:0] origin_t;

    typedef struct packed {
        logic [SEC_W-1:0] ref_sec;
        logic [NS_W-1:0]  ref_ns;
        origin_t          origin;
        logic [SEC_W-1:0] cur_sec;
        logic [NS_W-1:0]  cur_ns;
    } job_t;

    typedef struct packed {
        logic [SEC_W-1:0]  ref_sec;
        logic [FRAC_W-1:0] ref_frac;
        origin_t           origin;
        logic [SEC_W-1:0]  cur_sec;
        logic [FRAC_W-1:0] cur_frac;
    } reply_t;

endpackage

`default_nettype wire

@@ src/nsrb_front.sv @@
// front end: takes input words, keeps reference time, position and origin bytes
// depends on nsrb_pkg; pushes one job per finished request
`timescale 1ns / 1ps
`default_nettype none

module nsrb_front
    import nsrb_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_TDATA_W-1:0] s_tdata,
    input  wire logic                  s_tlast,
    input  wire logic                  s_tuser,
    output logic                       job_valid,
    input  wire logic                  job_ready,
    output job_t                       job_data
);

    logic [SEC_W-1:0] ref_sec_reg, ref_sec_next;
    logic [NS_W-1:0]  ref_ns_reg, ref_ns_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    origin_t          origin_reg, origin_next, origin_upd;
    in_data_t         in_d;
    logic             accept;

    assign in_d     = in_data_t'(s_tdata);
    assign s_tready = job_ready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        ref_sec_next = ref_sec_reg;
        ref_ns_next  = ref_ns_reg;
        pos_next     = pos_reg;
        origin_upd   = origin_reg;
        origin_next  = origin_reg;
        job_valid    = 1'b0;
        if (accept) begin
            if (s_tuser == ACT_SYNC) begin
                ref_sec_next = in_d.time_seconds;
                ref_ns_next  = in_d.time_nanoseconds;
            end else begin
                if (pos_reg < POS_W'(REPLY_LEN)) begin
                    if (pos_reg >= POS_W'(ORIGIN_AT)) begin
                        origin_upd[pos_reg[ORIGIN_IDX_W-1:0]] = in_d.data_byte;
                    end
                    pos_next = pos_reg + POS_W'(1);
                end
                origin_next = origin_upd;
                if (s_tlast) begin
                    job_valid   = 1'b1;
                    pos_next    = '0;
                    origin_next = '0;
                end
            end
        end
    end

    always_comb begin
        job_data.ref_sec = ref_sec_reg;
        job_data.ref_ns  = ref_ns_reg;
        job_data.origin  = origin_upd;
        job_data.cur_sec = in_d.time_seconds;
        job_data.cur_ns  = in_d.time_nanoseconds;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_sec_reg <= '0;
            ref_ns_reg  <= '0;
            pos_reg     <= '0;
            origin_reg  <= '0;
        end else begin
            ref_sec_reg <= ref_sec_next;
            ref_ns_reg  <= ref_ns_next;
            pos_reg     <= pos_next;
            origin_reg  <= origin_next;
        end
    end

endmodule

`default_nettype wire

@@ src/nsrb_queue.sv @@
// short job queue between front end and back end
// depends on nsrb_pkg for the job type and depth
`timescale 1ns / 1ps
`default_nettype none

module nsrb_queue
    import nsrb_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic wr_valid,
    output logic      wr_ready,
    input  job_t      wr_data,
    output logic      rd_valid,
    input  wire logic rd_ready,
    output job_t      rd_data
);

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              push, pop;

    assign wr_ready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ src/nsrb_conv.sv @@
// timestamp converter: unix seconds to ntp era, nanoseconds to 32-bit fraction
// reciprocal multiply by the low then the high half of the constant, two lanes; depends on nsrb_pkg
`timescale 1ns / 1ps
`default_nettype none

module nsrb_conv
    import nsrb_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic job_valid,
    output logic      job_ready,
    input  job_t      job_data,
    output logic      rep_valid,
    input  wire logic rep_ready,
    output reply_t    rep_data
);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic                   phase_reg, phase_next;
    logic [SEC_W-1:0]       ref_sec_reg, ref_sec_next;
    logic [SEC_W-1:0]       cur_sec_reg, cur_sec_next;
    origin_t                origin_reg, origin_next;
    logic [NS_W-1:0]        ref_ns_reg, ref_ns_next;
    logic [NS_W-1:0]        cur_ns_reg, cur_ns_next;
    logic [FRAC_PROD_W-1:0] ref_lo_reg, ref_lo_next;
    logic [FRAC_PROD_W-1:0] cur_lo_reg, cur_lo_next;
    logic [FRAC_W-1:0]      ref_q_reg, ref_q_next;
    logic [FRAC_W-1:0]      cur_q_reg, cur_q_next;
    logic [FRAC_M_W-1:0]    mul_k;
    logic [FRAC_PROD_W-1:0] ref_prod, cur_prod;
    logic [FRAC_SUM_W-1:0]  ref_sum, cur_sum;
    logic                   load;

    assign job_ready = !busy_reg && (!done_reg || rep_ready);
    assign load      = job_valid && job_ready;
    assign rep_valid = done_reg;

    // low half of the constant first, then the high half
    assign mul_k    = phase_reg ? FRAC_M_HI : FRAC_M_LO;
    assign ref_prod = FRAC_PROD_W'(ref_ns_reg) * FRAC_PROD_W'(mul_k);
    assign cur_prod = FRAC_PROD_W'(cur_ns_reg) * FRAC_PROD_W'(mul_k);
    assign ref_sum  = FRAC_SUM_W'(ref_prod) + FRAC_SUM_W'(ref_lo_reg[FRAC_PROD_W-1:FRAC_M_W]);
    assign cur_sum  = FRAC_SUM_W'(cur_prod) + FRAC_SUM_W'(cur_lo_reg[FRAC_PROD_W-1:FRAC_M_W]);

    always_comb begin
        busy_next    = busy_reg;
        done_next    = done_reg;
        phase_next   = phase_reg;
        ref_sec_next = ref_sec_reg;
        cur_sec_next = cur_sec_reg;
        origin_next  = origin_reg;
        ref_ns_next  = ref_ns_reg;
        cur_ns_next  = cur_ns_reg;
        ref_lo_next  = ref_lo_reg;
        cur_lo_next  = cur_lo_reg;
        ref_q_next   = ref_q_reg;
        cur_q_next   = cur_q_reg;
        if (done_reg && rep_ready) begin
            done_next = 1'b0;
        end
        if (load) begin
            busy_next    = 1'b1;
            phase_next   = 1'b0;
            ref_sec_next = job_data.ref_sec + EPOCH_SHIFT;
            cur_sec_next = job_data.cur_sec + EPOCH_SHIFT;
            origin_next  = job_data.origin;
            ref_ns_next  = job_data.ref_ns;
            cur_ns_next  = job_data.cur_ns;
        end else if (busy_reg) begin
            if (!phase_reg) begin
                ref_lo_next = ref_prod;
                cur_lo_next = cur_prod;
                phase_next  = 1'b1;
            end else begin
                ref_q_next = ref_sum[FRAC_LSB +: FRAC_W];
                cur_q_next = cur_sum[FRAC_LSB +: FRAC_W];
                busy_next  = 1'b0;
                done_next  = 1'b1;
            end
        end
    end

    always_comb begin
        rep_data.ref_sec  = ref_sec_reg;
        rep_data.ref_frac = ref_q_reg;
        rep_data.origin   = origin_reg;
        rep_data.cur_sec  = cur_sec_reg;
        rep_data.cur_frac = cur_q_reg;
    end

    always_ff @(posedge aclk) begin
        ref_sec_reg <= ref_sec_next;
        cur_sec_reg <= cur_sec_next;
        origin_reg  <= origin_next;
        ref_ns_reg  <= ref_ns_next;
        cur_ns_reg  <= cur_ns_next;
        ref_lo_reg  <= ref_lo_next;
        cur_lo_reg  <= cur_lo_next;
        ref_q_reg   <= ref_q_next;
        cur_q_reg   <= cur_q_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

@@ src/nsrb_emit.sv @@
// reply emitter: builds the 48-byte reply and shifts it out one word per cycle while m_tready is high
// depends on nsrb_pkg
`timescale 1ns / 1ps
`default_nettype none

module nsrb_emit
    import nsrb_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   rep_valid,
    output logic                        rep_ready,
    input  reply_t                      rep_data,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    output logic                        m_tlast
);

    logic               busy_reg, busy_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [REPLY_W-1:0] shift_reg, shift_next;
    logic [REPLY_W-1:0] built;
    logic               out_acc, end_word, load;

    assign built = {HDR_FLAGS, HDR_STRATUM, HDR_POLL, HDR_PREC,
                    56'h0, HDR_DISP,
                    REFID_G, REFID_P, REFID_S, 8'h00,
                    rep_data.ref_sec, rep_data.ref_frac,
                    rep_data.origin,
                    rep_data.cur_sec, rep_data.cur_frac,
                    rep_data.cur_sec, rep_data.cur_frac};

    assign m_tvalid  = busy_reg;
    assign m_tdata   = shift_reg[REPLY_W-1 -: 8];
    assign m_tlast   = (cnt_reg == CNT_W'(REPLY_LEN - 1));
    assign out_acc   = m_tvalid && m_tready;
    assign end_word  = out_acc && m_tlast;
    assign rep_ready = !busy_reg || end_word;
    assign load      = rep_valid && rep_ready;

    always_comb begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        if (load) begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            shift_next = built;
        end else if (end_word) begin
            busy_next = 1'b0;
        end else if (out_acc) begin
            cnt_next   = cnt_reg + CNT_W'(1);
            shift_next = {shift_reg[REPLY_W-9:0], 8'h00};
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ src/ntp_server_response_builder.sv @@
// top level of the ntp mode-4 server response builder
// depends on nsrb_pkg, nsrb_front, nsrb_queue, nsrb_conv, nsrb_emit
`timescale 1ns / 1ps
`default_nettype none

// Takes one input word per cycle: request bytes (tuser low) or a reference
// time update (tuser high). The last byte of a request (tlast) queues a reply
// job; the input stalls only while the two-entry job queue is full. Each job
// passes through the reciprocal multiplier that turns nanoseconds into the
// 32-bit ntp fraction, low half then high half, overlapped with the previous
// reply going out, so the output runs as 48-word bursts at one word per
// cycle while m_tready is high, back to back. On its way out a request passes
// the job queue, the converter registers and the emitter's shift register.

module ntp_server_response_builder
    import nsrb_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // data_byte[7:0], time_seconds[39:8], time_nanoseconds[69:40], zero pad
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                   s_tlast,
    // action
    input  wire logic                   s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // reply_byte[7:0]
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    output logic                        m_tlast
);

    logic   fj_valid, fj_ready;
    job_t   fj_data;
    logic   qj_valid, qj_ready;
    job_t   qj_data;
    logic   rp_valid, rp_ready;
    reply_t rp_data;

    nsrb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .job_valid (fj_valid),
        .job_ready (fj_ready),
        .job_data  (fj_data)
    );

    nsrb_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fj_valid),
        .wr_ready (fj_ready),
        .wr_data  (fj_data),
        .rd_valid (qj_valid),
        .rd_ready (qj_ready),
        .rd_data  (qj_data)
    );

    nsrb_conv u_conv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (qj_valid),
        .job_ready (qj_ready),
        .job_data  (qj_data),
        .rep_valid (rp_valid),
        .rep_ready (rp_ready),
        .rep_data  (rp_data)
    );

    nsrb_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rep_valid (rp_valid),
        .rep_ready (rp_ready),
        .rep_data  (rp_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// self-checking bench for the ntp server response builder
// drives request bytes and sync updates, predicts every 48-word reply, uses nsrb_pkg
`timescale 1ns / 1ps

module testbench
    import nsrb_pkg::*;
();

    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 60;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic [7:0] reply_byte;
        logic       reply_last;
    } reply_word_t;

    typedef struct {
        action_t     act;
        logic [7:0]  base;
        int          count;
        bit          last;
        logic [31:0] secs;
        logic [29:0] ns;
        bit          typed;
        logic [31:0] exp_sec;
        logic [31:0] exp_frac;
    } stim_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tlast;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    ntp_server_response_builder dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    // model state
    logic [31:0] sync_sec;
    logic [29:0] sync_ns;
    logic [7:0]  origin_bytes [ORIGIN_LEN];
    int          req_pos;

    reply_word_t pending_reply [$];
    int          fail_count;
    int          cycle_count;
    bit          sender_flat;
    bit          receiver_flat;

    // directed rows: a run of count request bytes, or one sync word
    stim_row_t directed_rows [13] = '{
        '{ACT_REQUEST, 8'h00, 1,  1'b1, 32'h0000_0000, 30'd0,
          1'b1, 32'h83AA_7E80, 32'h0000_0000},
        '{ACT_SYNC,    8'h00, 1,  1'b0, 32'hFFFF_FFFF, 30'd999999999,
          1'b0, 32'h0, 32'h0},
        '{ACT_REQUEST, 8'hFF, 1,  1'b1, 32'hFFFF_FFFF, 30'd999999999,
          1'b1, 32'h83AA_7E7F, 32'hFFFF_FFFB},
        '{ACT_REQUEST, 8'h00, 3,  1'b1, 32'd12345678, 30'd500000000,
          1'b0, 32'h0, 32'h0},
        '{ACT_REQUEST, 8'h10, 42, 1'b1, 32'd87654321, 30'd123456789,
          1'b0, 32'h0, 32'h0},
        '{ACT_REQUEST, 8'hC0, 49, 1'b1, 32'h5A5A_A5A5, 30'd1,
          1'b0, 32'h0, 32'h0},
        '{ACT_SYNC,    8'h00, 1,  1'b0, 32'h0000_0000, 30'h3FFF_FFFF,
          1'b0, 32'h0, 32'h0},
        '{ACT_REQUEST, 8'hF8, 1,  1'b1, 32'h8000_0000, 30'h3FFF_FFFF,
          1'b1, 32'h03AA_7E80, 32'h12E0_BE7E},
        '{ACT_REQUEST, 8'h20, 40, 1'b0, 32'h1111_1111, 30'd7,
          1'b0, 32'h0, 32'h0},
        '{ACT_SYNC,    8'hA5, 1,  1'b1, 32'h7FFF_FFFF, 30'd999999999,
          1'b0, 32'h0, 32'h0},
        '{ACT_REQUEST, 8'h55, 8,  1'b1, 32'h2222_2222, 30'd250000000,
          1'b0, 32'h0, 32'h0},
        '{ACT_REQUEST, 8'hFF, 1,  1'b1, 32'h7C55_8180, 30'd1000000000,
          1'b1, 32'h0000_0000, 32'h0000_0000},
        '{ACT_REQUEST, 8'h80, 2,  1'b1, 32'h7FFF_FFFF, 30'd999999999,
          1'b0, 32'h0, 32'h0}
    };

    function automatic logic [31:0] era_sec(input logic [31:0] secs);
        return secs + EPOCH_SHIFT;
    endfunction

    function automatic logic [31:0] ns_to_frac(input logic [29:0] ns);
        logic [63:0] quot;
        quot = {2'b00, ns, 32'd0} / 64'd1000000000;
        return quot[31:0];
    endfunction

    task automatic predict_reply(input action_t act, input logic [7:0] data,
                                 input logic last, input logic [31:0] secs,
                                 input logic [29:0] ns, input bit typed,
                                 input logic [31:0] exp_sec, input logic [31:0] exp_frac);
        logic [7:0]  reply [REPLY_LEN];
        logic [31:0] ref_s, ref_f, cur_s, cur_f;
        reply_word_t w;
        if (act == ACT_SYNC) begin
            sync_sec = secs;
            sync_ns  = ns;
            return;
        end
        if (req_pos < REPLY_LEN) begin
            if (req_pos >= ORIGIN_AT)
                origin_bytes[req_pos - ORIGIN_AT] = data;
            req_pos++;
        end
        if (!last)
            return;
        ref_s = era_sec(sync_sec);
        ref_f = ns_to_frac(sync_ns);
        cur_s = typed ? exp_sec : era_sec(secs);
        cur_f = typed ? exp_frac : ns_to_frac(ns);
        for (int k = 0; k < REPLY_LEN; k++)
            reply[k] = 8'h00;
        reply[0]  = HDR_FLAGS;
        reply[1]  = HDR_STRATUM;
        reply[2]  = HDR_POLL;
        reply[3]  = HDR_PREC;
        reply[11] = HDR_DISP;
        reply[12] = REFID_G;
        reply[13] = REFID_P;
        reply[14] = REFID_S;
        for (int i = 0; i < 4; i++) begin
            reply[16 + i] = ref_s[31 - 8*i -: 8];
            reply[20 + i] = ref_f[31 - 8*i -: 8];
            reply[32 + i] = cur_s[31 - 8*i -: 8];
            reply[36 + i] = cur_f[31 - 8*i -: 8];
            reply[40 + i] = cur_s[31 - 8*i -: 8];
            reply[44 + i] = cur_f[31 - 8*i -: 8];
        end
        for (int i = 0; i < ORIGIN_LEN; i++)
            reply[24 + i] = origin_bytes[i];
        for (int k = 0; k < REPLY_LEN; k++) begin
            w.reply_byte = reply[k];
            w.reply_last = (k == REPLY_LEN - 1);
            pending_reply.push_back(w);
        end
        req_pos = 0;
        for (int i = 0; i < ORIGIN_LEN; i++)
            origin_bytes[i] = 8'h00;
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input action_t act, input logic [7:0] data,
                             input logic last, input logic [31:0] secs,
                             input logic [29:0] ns, input bit typed,
                             input logic [31:0] exp_sec, input logic [31:0] exp_frac);
        int       gap;
        in_data_t w;
        if ($urandom_range(0, 39) == 0)
            sender_flat = !sender_flat;
        gap = sender_flat ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        w.pad              = 2'b00;
        w.time_nanoseconds = ns;
        w.time_seconds     = secs;
        w.data_byte        = data;
        s_tdata  <= w;
        s_tlast  <= last;
        s_tuser  <= act;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (s_tready !== 1'b1);
        predict_reply(act, data, last, secs, ns, typed, exp_sec, exp_frac);
        @(negedge aclk);
    endtask

    function automatic logic [29:0] random_ns();
        if ($urandom_range(0, 3) == 0)
            return 30'($urandom_range(0, 30'h3FFF_FFFF));
        return 30'($urandom_range(0, 999999999));
    endfunction

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // cycle limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("ntp_server_response_builder test failed");
        $finish;
    end

    // result side: random stalls per word
    initial begin
        int stall;
        m_tready = 1'b0;
        receiver_flat = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0)
                receiver_flat = !receiver_flat;
            stall = receiver_flat ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            @(negedge aclk);
        end
    end

    // compare every accepted word with the oldest expectation
    always @(posedge aclk) begin
        reply_word_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (pending_reply.size() == 0) begin
                $error("unexpected reply word: reply_byte %02h reply_last %0b",
                       m_tdata, m_tlast);
                fail_count++;
            end else begin
                want = pending_reply.pop_front();
                if (m_tdata !== want.reply_byte) begin
                    $error("reply_byte mismatch: expected %02h actual %02h",
                           want.reply_byte, m_tdata);
                    fail_count++;
                end
                if (m_tlast !== want.reply_last) begin
                    $error("reply_last mismatch: expected %0b actual %0b",
                           want.reply_last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int          sent;
        int          len;
        int          kind;
        bit          end_it;
        logic [31:0] secs;
        logic [29:0] ns;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        s_tuser     = 1'b0;
        fail_count  = 0;
        sender_flat = 1'b0;
        sync_sec    = '0;
        sync_ns     = '0;
        req_pos     = 0;
        for (int i = 0; i < ORIGIN_LEN; i++)
            origin_bytes[i] = 8'h00;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[r]) begin
            for (int j = 0; j < directed_rows[r].count; j++)
                send_word(directed_rows[r].act, 8'(directed_rows[r].base + j),
                          directed_rows[r].last && (j == directed_rows[r].count - 1),
                          directed_rows[r].secs, directed_rows[r].ns,
                          directed_rows[r].typed,
                          directed_rows[r].exp_sec, directed_rows[r].exp_frac);
        end

        // mostly whole requests with random content, plus syncs and odd lengths
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 15) begin
                send_word(ACT_SYNC, 8'($urandom), 1'($urandom), $urandom, random_ns(),
                          1'b0, 32'h0, 32'h0);
                sent++;
            end else begin
                if (kind < 65)
                    len = REPLY_LEN;
                else if (kind < 85)
                    len = $urandom_range(1, REPLY_LEN - 1);
                else
                    len = $urandom_range(REPLY_LEN + 1, REPLY_LEN + 8);
                if (len > RANDOM_ITEMS - sent)
                    len = RANDOM_ITEMS - sent;
                end_it = ($urandom_range(0, 9) != 0);
                for (int j = 0; j < len; j++) begin
                    secs = $urandom;
                    ns   = random_ns();
                    if ($urandom_range(0, 29) == 0) begin
                        send_word(ACT_SYNC, 8'($urandom), 1'($urandom), secs, ns,
                                  1'b0, 32'h0, 32'h0);
                        sent++;
                    end
                    send_word(ACT_REQUEST, 8'($urandom), end_it && (j == len - 1),
                              secs, ns, 1'b0, 32'h0, 32'h0);
                    sent++;
                end
            end
        end
        s_tvalid <= 1'b0;

        while (pending_reply.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("ntp_server_response_builder test passed");
        else
            $display("ntp_server_response_builder test failed");
        $finish;
    end

endmodule

@@ sim.f @@
src/nsrb_pkg.sv
src/nsrb_front.sv
src/nsrb_queue.sv
src/nsrb_conv.sv
src/nsrb_emit.sv
src/ntp_server_response_builder.sv
bench/testbench.sv
